// ----- src/ljc_pkg.sv -----
package ljc_pkg;

  localparam int RECENT_LOADS_DEF = 50;
  localparam int PAIR_ENTRIES_DEF = 64;
  localparam int JUMP_ENTRIES_DEF = 64;

  localparam int ADDR_W  = 64;
  localparam int SIZE_W  = 8;
  localparam int TALLY_W = 31;

  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 168;
  localparam int CFG_IDX_W  = 8;

  localparam logic [SIZE_W-1:0]  REQUIRED_SIZE = 8'd8;
  localparam logic [TALLY_W-1:0] TALLY_MAX     = 31'h7FFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_MODULE_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_LIMIT = 8'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_JUMP = 1'b1;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] instr_addr;
    logic [SIZE_W-1:0] read_size;
    logic              read_ok;
    logic [ADDR_W-1:0] loaded_value;
    logic [ADDR_W-1:0] target_addr;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               matched;
    logic [ADDR_W-1:0]  load_offset;
    logic [ADDR_W-1:0]  jump_offset;
    logic [TALLY_W-1:0] pair_count;
    logic               pair_table_full;
    logic               jump_is_new;
    logic               jump_table_full;
  } result_t;

endpackage

// ----- src/ljc_cmp.sv -----
module ljc_cmp (
  input  logic [ljc_pkg::ADDR_W-1:0] a_lo,
  input  logic [ljc_pkg::ADDR_W-1:0] b_lo,
  input  logic [ljc_pkg::ADDR_W-1:0] a_hi,
  input  logic [ljc_pkg::ADDR_W-1:0] b_hi,
  input  logic                       use_hi,
  output logic                       eq
);

  // The high word takes part only for the two-key pair lookup.
  assign eq = (a_lo == b_lo) && (!use_hi || (a_hi == b_hi));

endmodule

// ----- src/ljc_seq.sv -----
module ljc_seq #(
  parameter int RECENT_LOADS = ljc_pkg::RECENT_LOADS_DEF,
  parameter int PAIR_ENTRIES = ljc_pkg::PAIR_ENTRIES_DEF,
  parameter int JUMP_ENTRIES = ljc_pkg::JUMP_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ljc_pkg::ADDR_W-1:0] module_base,
  input  logic [ljc_pkg::ADDR_W-1:0] module_limit,
  input  logic                       in_valid,
  input  ljc_pkg::item_t             item,
  output logic                       in_ready,
  input  logic                       out_free,
  output logic                       done,
  output ljc_pkg::result_t           result
);

  localparam int RI_W = (RECENT_LOADS > 1) ? $clog2(RECENT_LOADS) : 1;
  localparam int RF_W = $clog2(RECENT_LOADS + 1);
  localparam int PI_W = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
  localparam int PU_W = $clog2(PAIR_ENTRIES + 1);
  localparam int JI_W = (JUMP_ENTRIES > 1) ? $clog2(JUMP_ENTRIES) : 1;
  localparam int JU_W = $clog2(JUMP_ENTRIES + 1);
  localparam int SC_A = (RF_W > PU_W) ? RF_W : PU_W;
  localparam int SC_W = (SC_A > JU_W) ? SC_A : JU_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_OFFS  = 8'b0000_0100,
    S_EXEC  = 8'b0000_1000,
    S_RSCAN = 8'b0001_0000,
    S_PSCAN = 8'b0010_0000,
    S_JSCAN = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  ljc_pkg::item_t             cur;
  logic                       in_range;
  logic [ljc_pkg::ADDR_W-1:0] joff;
  logic [ljc_pkg::ADDR_W-1:0] toff;
  ljc_pkg::result_t           res;

  logic [SC_W-1:0] scan_idx;
  logic [SC_W-1:0] cmp_idx;
  logic            cmp_valid;

  logic [RF_W-1:0] recent_fill;
  logic [RI_W-1:0] recent_wptr;
  logic [PU_W-1:0] pair_used;
  logic [JU_W-1:0] jump_used;

  logic [ljc_pkg::ADDR_W-1:0]  recent_pc_mem  [RECENT_LOADS];
  logic [ljc_pkg::ADDR_W-1:0]  recent_val_mem [RECENT_LOADS];
  logic [ljc_pkg::ADDR_W-1:0]  pair_lkey_mem  [PAIR_ENTRIES];
  logic [ljc_pkg::ADDR_W-1:0]  pair_jkey_mem  [PAIR_ENTRIES];
  logic [ljc_pkg::TALLY_W-1:0] pair_tally_mem [PAIR_ENTRIES];
  logic [ljc_pkg::ADDR_W-1:0]  jump_mem       [JUMP_ENTRIES];

  logic [ljc_pkg::ADDR_W-1:0]  rd_pc;
  logic [ljc_pkg::ADDR_W-1:0]  rd_val;
  logic [ljc_pkg::ADDR_W-1:0]  rd_lkey;
  logic [ljc_pkg::ADDR_W-1:0]  rd_jkey;
  logic [ljc_pkg::TALLY_W-1:0] rd_tally;
  logic [ljc_pkg::ADDR_W-1:0]  rd_jump;

  logic [SC_W-1:0]             scan_limit;
  logic                        scan_more;
  logic                        eq;
  logic                        hit;
  logic                        issue;
  logic [ljc_pkg::ADDR_W-1:0]  a_lo;
  logic [ljc_pkg::ADDR_W-1:0]  b_lo;
  logic [ljc_pkg::ADDR_W-1:0]  a_hi;
  logic [ljc_pkg::ADDR_W-1:0]  b_hi;
  logic                        use_hi;
  logic                        load_ok;
  logic                        recent_we;
  logic [RI_W-1:0]             recent_slot;
  logic                        pair_full;
  logic                        pair_key_we;
  logic                        pair_tally_we;
  logic [PI_W-1:0]             pair_waddr;
  logic [ljc_pkg::TALLY_W-1:0] tally_sat;
  logic [ljc_pkg::TALLY_W-1:0] tally_wdata;
  logic                        jump_full;
  logic                        jump_we;

  ljc_cmp u_cmp (
    .a_lo   (a_lo),
    .b_lo   (b_lo),
    .a_hi   (a_hi),
    .b_hi   (b_hi),
    .use_hi (use_hi),
    .eq     (eq)
  );

  assign in_ready = (state == S_IDLE);
  assign done     = (state == S_DONE);
  assign result   = res;

  always_comb begin
    a_lo       = '0;
    b_lo       = '0;
    a_hi       = '0;
    b_hi       = '0;
    use_hi     = 1'b0;
    scan_limit = '0;
    case (state)
      S_RSCAN: begin
        a_lo       = rd_val;
        b_lo       = toff;
        scan_limit = SC_W'(recent_fill);
      end
      S_PSCAN: begin
        a_lo       = rd_jkey;
        b_lo       = joff;
        a_hi       = rd_lkey;
        b_hi       = res.load_offset;
        use_hi     = 1'b1;
        scan_limit = SC_W'(pair_used);
      end
      S_JSCAN: begin
        a_lo       = rd_jump;
        b_lo       = joff;
        scan_limit = SC_W'(jump_used);
      end
      default: begin
        scan_limit = '0;
      end
    endcase
  end

  assign scan_more = (scan_idx < scan_limit);
  assign hit       = cmp_valid && eq;
  assign issue     = !hit && scan_more;

  assign load_ok = in_range && (cur.command == ljc_pkg::CMD_LOAD) &&
                   (cur.read_size == ljc_pkg::REQUIRED_SIZE) && cur.read_ok;
  assign recent_we   = (state == S_EXEC) && load_ok;
  assign recent_slot = (recent_fill < RF_W'(RECENT_LOADS)) ? recent_fill[RI_W-1:0] :
                       recent_wptr;

  assign pair_full     = (pair_used >= PU_W'(PAIR_ENTRIES));
  assign tally_sat     = (rd_tally == ljc_pkg::TALLY_MAX) ? rd_tally : rd_tally + 1'b1;
  assign pair_key_we   = (state == S_PSCAN) && !hit && !scan_more && !pair_full;
  assign pair_tally_we = ((state == S_PSCAN) && hit) || pair_key_we;
  assign pair_waddr    = hit ? cmp_idx[PI_W-1:0] : pair_used[PI_W-1:0];
  assign tally_wdata   = hit ? tally_sat : ljc_pkg::TALLY_W'(1);

  assign jump_full = (jump_used >= JU_W'(JUMP_ENTRIES));
  assign jump_we   = (state == S_JSCAN) && !hit && !scan_more && !jump_full;

  always_ff @(posedge clk) begin
    if (recent_we) begin
      recent_pc_mem[recent_slot]  <= joff;
      recent_val_mem[recent_slot] <= toff;
    end
    if ((state == S_RSCAN) && issue) begin
      rd_pc  <= recent_pc_mem[scan_idx[RI_W-1:0]];
      rd_val <= recent_val_mem[scan_idx[RI_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pair_key_we) begin
      pair_lkey_mem[pair_waddr] <= res.load_offset;
      pair_jkey_mem[pair_waddr] <= joff;
    end
    if (pair_tally_we) begin
      pair_tally_mem[pair_waddr] <= tally_wdata;
    end
    if ((state == S_PSCAN) && issue) begin
      rd_lkey  <= pair_lkey_mem[scan_idx[PI_W-1:0]];
      rd_jkey  <= pair_jkey_mem[scan_idx[PI_W-1:0]];
      rd_tally <= pair_tally_mem[scan_idx[PI_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (jump_we) begin
      jump_mem[jump_used[JI_W-1:0]] <= joff;
    end
    if ((state == S_JSCAN) && issue) begin
      rd_jump <= jump_mem[scan_idx[JI_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      recent_fill <= '0;
      recent_wptr <= '0;
      pair_used   <= '0;
      jump_used   <= '0;
      cmp_valid   <= 1'b0;
      scan_idx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur   <= item;
            res   <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          in_range <= (cur.instr_addr >= module_base) && (cur.instr_addr <= module_limit);
          state    <= S_OFFS;
        end
        S_OFFS: begin
          joff  <= cur.instr_addr - module_base;
          toff  <= ((cur.command == ljc_pkg::CMD_JUMP) ? cur.target_addr :
                    cur.loaded_value) - module_base;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (!in_range) begin
            state <= S_DONE;
          end else if (cur.command == ljc_pkg::CMD_LOAD) begin
            if (load_ok) begin
              res.accepted <= 1'b1;
              if (recent_fill < RF_W'(RECENT_LOADS)) begin
                recent_fill <= recent_fill + 1'b1;
              end
              recent_wptr <= (recent_wptr == RI_W'(RECENT_LOADS - 1)) ? '0 :
                             recent_wptr + 1'b1;
            end
            state <= S_DONE;
          end else begin
            res.accepted    <= 1'b1;
            res.jump_offset <= joff;
            scan_idx        <= '0;
            cmp_valid       <= 1'b0;
            state           <= S_RSCAN;
          end
        end
        S_RSCAN: begin
          if (hit) begin
            res.matched     <= 1'b1;
            res.load_offset <= rd_pc;
            scan_idx        <= '0;
            cmp_valid       <= 1'b0;
            state           <= S_PSCAN;
          end else if (scan_more) begin
            cmp_idx   <= scan_idx;
            cmp_valid <= 1'b1;
            scan_idx  <= scan_idx + 1'b1;
          end else begin
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            state     <= S_JSCAN;
          end
        end
        S_PSCAN: begin
          if (hit) begin
            res.pair_count <= tally_sat;
            recent_fill    <= '0;
            scan_idx       <= '0;
            cmp_valid      <= 1'b0;
            state          <= S_JSCAN;
          end else if (scan_more) begin
            cmp_idx   <= scan_idx;
            cmp_valid <= 1'b1;
            scan_idx  <= scan_idx + 1'b1;
          end else begin
            if (pair_full) begin
              res.pair_table_full <= 1'b1;
            end else begin
              res.pair_count <= ljc_pkg::TALLY_W'(1);
              pair_used      <= pair_used + 1'b1;
            end
            recent_fill <= '0;
            scan_idx    <= '0;
            cmp_valid   <= 1'b0;
            state       <= S_JSCAN;
          end
        end
        S_JSCAN: begin
          if (hit) begin
            cmp_valid <= 1'b0;
            state     <= S_DONE;
          end else if (scan_more) begin
            cmp_idx   <= scan_idx;
            cmp_valid <= 1'b1;
            scan_idx  <= scan_idx + 1'b1;
          end else begin
            if (jump_full) begin
              res.jump_table_full <= 1'b1;
            end else begin
              res.jump_is_new <= 1'b1;
              jump_used       <= jump_used + 1'b1;
            end
            cmp_valid <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/load_to_indirect_jump_correlator.sv -----
// A load or an out-of-range event passes S_CHECK, S_OFFS and S_EXEC and is registered on the output from S_DONE.
// A jump result is registered after a scan of the load buffer, then of the pair table (only on a
// load-buffer match), then of the jump set, one shared comparator visiting one entry per cycle.
// Throughput: one event at a time; s_tready returns in the same cycle that the result is registered.
// Reset (rst, synchronous) empties the buffer and both tables and clears both
// configuration registers; memory contents are not cleared.
module load_to_indirect_jump_correlator #(
  parameter int RECENT_LOADS = ljc_pkg::RECENT_LOADS_DEF,
  parameter int PAIR_ENTRIES = ljc_pkg::PAIR_ENTRIES_DEF,
  parameter int JUMP_ENTRIES = ljc_pkg::JUMP_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // instr_addr, read_size, read_ok, loaded_value, target_addr, zero pad
  input  logic [ljc_pkg::IN_DATA_W-1:0] s_tdata,
  // command
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // accepted, matched, load_offset, jump_offset, pair_count, pair_table_full,
  // jump_is_new, jump_table_full, zero pad
  output logic [ljc_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ljc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ljc_pkg::ADDR_W-1:0]    cfg_data
);

  logic [ljc_pkg::ADDR_W-1:0] module_base;
  logic [ljc_pkg::ADDR_W-1:0] module_limit;
  ljc_pkg::item_t             item;
  ljc_pkg::result_t           result;
  logic                       done;
  logic                       out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_base  <= '0;
      module_limit <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ljc_pkg::REG_MODULE_BASE:  module_base  <= cfg_data;
        ljc_pkg::REG_MODULE_LIMIT: module_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign item.command      = s_tuser;
  assign item.instr_addr   = s_tdata[63:0];
  assign item.read_size    = s_tdata[71:64];
  assign item.read_ok      = s_tdata[72];
  assign item.loaded_value = s_tdata[136:73];
  assign item.target_addr  = s_tdata[200:137];

  assign out_free = !m_tvalid || m_tready;

  ljc_seq #(
    .RECENT_LOADS (RECENT_LOADS),
    .PAIR_ENTRIES (PAIR_ENTRIES),
    .JUMP_ENTRIES (JUMP_ENTRIES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .module_base  (module_base),
    .module_limit (module_limit),
    .in_valid     (s_tvalid),
    .item         (item),
    .in_ready     (s_tready),
    .out_free     (out_free),
    .done         (done),
    .result       (result)
  );

  // The output register frees the sequencer as soon as the result is handed over.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      m_tdata <= {4'b0000,
                  result.jump_table_full,
                  result.jump_is_new,
                  result.pair_table_full,
                  result.pair_count,
                  result.jump_offset,
                  result.load_offset,
                  result.matched,
                  result.accepted};
    end
  end

endmodule

// ----- bench/tb_load_to_indirect_jump_correlator.sv -----
module tb_load_to_indirect_jump_correlator;
  import ljc_pkg::*;

  class correlator_scoreboard;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  limit;
    logic [ADDR_W-1:0]  load_pc [RECENT_LOADS_DEF];
    logic [ADDR_W-1:0]  load_val [RECENT_LOADS_DEF];
    int                 fill;
    int                 wr_ptr;
    logic [ADDR_W-1:0]  pair_lkey [PAIR_ENTRIES_DEF];
    logic [ADDR_W-1:0]  pair_jkey [PAIR_ENTRIES_DEF];
    logic [TALLY_W-1:0] pair_tally [PAIR_ENTRIES_DEF];
    int                 pairs_used;
    logic [ADDR_W-1:0]  jump_keys [JUMP_ENTRIES_DEF];
    int                 jumps_used;
    result_t            expected_results [$];
    int                 failures;

    function new();
      base = '0;
      limit = '0;
      fill = 0;
      wr_ptr = 0;
      pairs_used = 0;
      jumps_used = 0;
      failures = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
      if (idx == REG_MODULE_BASE) begin
        base = value;
      end else if (idx == REG_MODULE_LIMIT) begin
        limit = value;
      end
    endfunction

    function void tally_pair(input logic [ADDR_W-1:0] lkey, input logic [ADDR_W-1:0] jkey,
                             output logic [TALLY_W-1:0] cnt, output bit full);
      full = 0;
      for (int i = 0; i < pairs_used; i++) begin
        if (pair_lkey[i] == lkey && pair_jkey[i] == jkey) begin
          if (pair_tally[i] != TALLY_MAX) pair_tally[i]++;
          cnt = pair_tally[i];
          return;
        end
      end
      if (pairs_used >= PAIR_ENTRIES_DEF) begin
        full = 1;
        cnt = '0;
        return;
      end
      pair_lkey[pairs_used] = lkey;
      pair_jkey[pairs_used] = jkey;
      pair_tally[pairs_used] = 1;
      pairs_used++;
      cnt = 1;
    endfunction

    function void record_jump(input logic [ADDR_W-1:0] key, output bit is_new,
                              output bit full);
      is_new = 0;
      full = 0;
      for (int i = 0; i < jumps_used; i++) begin
        if (jump_keys[i] == key) return;
      end
      if (jumps_used >= JUMP_ENTRIES_DEF) begin
        full = 1;
        return;
      end
      jump_keys[jumps_used] = key;
      jumps_used++;
      is_new = 1;
    endfunction

    function result_t correlate(item_t ev);
      result_t            r;
      logic [ADDR_W-1:0]  joff;
      logic [ADDR_W-1:0]  toff;
      logic [TALLY_W-1:0] cnt;
      int                 slot;
      bit                 full;
      bit                 is_new;
      r = '0;
      if (ev.instr_addr < base || ev.instr_addr > limit) return r;
      if (ev.command == CMD_LOAD) begin
        if (ev.read_size != REQUIRED_SIZE || !ev.read_ok) return r;
        if (fill < RECENT_LOADS_DEF) begin
          slot = fill;
          fill++;
        end else begin
          slot = wr_ptr;
        end
        load_pc[slot] = ev.instr_addr - base;
        load_val[slot] = ev.loaded_value - base;
        wr_ptr = (wr_ptr + 1 == RECENT_LOADS_DEF) ? 0 : wr_ptr + 1;
        r.accepted = 1'b1;
        return r;
      end
      joff = ev.instr_addr - base;
      toff = ev.target_addr - base;
      r.accepted = 1'b1;
      r.jump_offset = joff;
      for (int i = 0; i < fill; i++) begin
        if (load_val[i] == toff) begin
          tally_pair(load_pc[i], joff, cnt, full);
          r.matched = 1'b1;
          r.load_offset = load_pc[i];
          r.pair_count = cnt;
          r.pair_table_full = full;
          fill = 0;
          break;
        end
      end
      record_jump(joff, is_new, full);
      r.jump_is_new = is_new;
      r.jump_table_full = full;
      return r;
    endfunction

    function void note_event(item_t ev);
      expected_results.insert(expected_results.size(), correlate(ev));
    endfunction

    function void check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %h, got %h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat arrived with no event awaiting it");
        failures++;
        return;
      end
      want = expected_results.pop_front();
      check_field("accepted", want.accepted, got.accepted);
      check_field("matched", want.matched, got.matched);
      check_field("load_offset", want.load_offset, got.load_offset);
      check_field("jump_offset", want.jump_offset, got.jump_offset);
      check_field("pair_count", want.pair_count, got.pair_count);
      check_field("pair_table_full", want.pair_table_full, got.pair_table_full);
      check_field("jump_is_new", want.jump_is_new, got.jump_is_new);
      check_field("jump_table_full", want.jump_table_full, got.jump_table_full);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ADDR_W-1:0]     cfg_data;

  correlator_scoreboard sb;
  logic [ADDR_W-1:0]    cur_base;
  logic [ADDR_W-1:0]    cur_limit;
  bit                   steady;
  int                   sent_in_phase;
  int                   stall;
  logic [ADDR_W-1:0]    phase_base [7];
  logic [ADDR_W-1:0]    phase_limit [7];
  int                   phase_items [7];
  int                   pick;
  int                   run_len;

  load_to_indirect_jump_correlator dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12000000;
    $display("load_to_indirect_jump_correlator regression: fail");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Places an offset inside the current module range; an empty range, and one call in ten, gives a random address.
  function automatic logic [ADDR_W-1:0] module_pc(logic [ADDR_W-1:0] off);
    logic [ADDR_W-1:0] span;
    if (cur_limit < cur_base || $urandom_range(0, 9) == 0) return rand64();
    span = cur_limit - cur_base;
    if (span != '1 && off > span) off = off % (span + 1);
    return cur_base + off;
  endfunction

  function automatic logic [ADDR_W-1:0] pooled_value();
    if ($urandom_range(0, 4) == 0) return rand64();
    return cur_base + 64'($urandom_range(0, 15) * 16);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_event(item_t ev);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[63:0] = ev.instr_addr;
    d[71:64] = ev.read_size;
    d[72] = ev.read_ok;
    d[136:73] = ev.loaded_value;
    d[200:137] = ev.target_addr;
    return d;
  endfunction

  function automatic result_t unpack_result(logic [OUT_DATA_W-1:0] d);
    result_t r;
    r.accepted = d[0];
    r.matched = d[1];
    r.load_offset = d[65:2];
    r.jump_offset = d[129:66];
    r.pair_count = d[160:130];
    r.pair_table_full = d[161];
    r.jump_is_new = d[162];
    r.jump_table_full = d[163];
    return r;
  endfunction

  task automatic send_event(item_t ev);
    int n;
    n = pick_gap();
    if (n > 0) begin
      s_tvalid = 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = pack_event(ev);
    s_tuser = ev.command;
    do @(posedge clk); while (!s_tready);
    sb.note_event(ev);
    sent_in_phase++;
    @(negedge clk);
  endtask

  task automatic send_fields(logic cmd, logic [ADDR_W-1:0] pc, logic [SIZE_W-1:0] size,
                             logic ok, logic [ADDR_W-1:0] value, logic [ADDR_W-1:0] target);
    item_t ev;
    ev.command = cmd;
    ev.instr_addr = pc;
    ev.read_size = size;
    ev.read_ok = ok;
    ev.loaded_value = value;
    ev.target_addr = target;
    send_event(ev);
  endtask

  task automatic send_load();
    send_fields(CMD_LOAD, module_pc(64'($urandom_range(0, 15) * 8)),
                ($urandom_range(0, 19) == 0) ? SIZE_W'($urandom_range(0, 255)) : REQUIRED_SIZE,
                ($urandom_range(0, 19) != 0), pooled_value(), rand64());
  endtask

  task automatic send_jump();
    send_fields(CMD_JUMP, module_pc(64'($urandom_range(0, 127) * 4 + 'h400)),
                SIZE_W'($urandom_range(0, 255)), 1'($urandom()), rand64(), pooled_value());
  endtask

  task automatic send_noise();
    send_fields(1'($urandom()), ($urandom_range(0, 1) == 0) ? module_pc(rand64()) : rand64(),
                SIZE_W'($urandom_range(0, 255)), 1'($urandom()), rand64(), rand64());
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] limit);
    wait_drained();
    write_register(REG_MODULE_BASE, base);
    write_register(REG_MODULE_LIMIT, limit);
    cur_base = base;
    cur_limit = limit;
  endtask

  task automatic load_run(int n);
    repeat (n) send_load();
  endtask

  initial begin
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(unpack_result(m_tdata));
  end

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_base = '0;
    cur_limit = '0;
    steady = 1'b0;
    sent_in_phase = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    configure(64'h1000, 64'h1FFF);
    send_fields(CMD_LOAD, 64'h0FFF, REQUIRED_SIZE, 1'b1, 64'h1500, 64'h0);
    send_fields(CMD_LOAD, 64'h2000, REQUIRED_SIZE, 1'b1, 64'h1500, 64'h0);
    send_fields(CMD_JUMP, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 64'h0, 64'h1500);
    send_fields(CMD_LOAD, 64'h1000, 8'h04, 1'b1, 64'h1500, 64'h0);
    send_fields(CMD_LOAD, 64'h1000, REQUIRED_SIZE, 1'b0, 64'h1500, 64'h0);
    send_fields(CMD_LOAD, 64'h1000, 8'hFF, 1'b1, 64'h1500, 64'h0);
    send_fields(CMD_LOAD, 64'h1000, REQUIRED_SIZE, 1'b1, 64'h1500, 64'h0);
    send_fields(CMD_LOAD, 64'h1FFF, REQUIRED_SIZE, 1'b1, 64'h0, 64'h0);
    send_fields(CMD_JUMP, 64'h1100, REQUIRED_SIZE, 1'b1, 64'h0, 64'h1500);
    send_fields(CMD_JUMP, 64'h1100, REQUIRED_SIZE, 1'b1, 64'h0, 64'h1500);
    send_fields(CMD_LOAD, 64'h1000, REQUIRED_SIZE, 1'b1, 64'h1500, 64'h0);
    send_fields(CMD_JUMP, 64'h1100, REQUIRED_SIZE, 1'b1, 64'h0, 64'h1500);
    send_fields(CMD_LOAD, 64'h1010, REQUIRED_SIZE, 1'b1, 64'h0, 64'h0);
    send_fields(CMD_JUMP, 64'h1200, 8'h00, 1'b0, '1, 64'h0);
    send_fields(CMD_LOAD, 64'h1FFF, REQUIRED_SIZE, 1'b1, '1, '1);
    send_fields(CMD_LOAD, 64'h1008, REQUIRED_SIZE, 1'b1, '1, 64'h0);
    send_fields(CMD_JUMP, 64'h1FFF, 8'hFF, 1'b1, 64'h0, '1);
    send_fields(CMD_JUMP, 64'h1000, REQUIRED_SIZE, 1'b1, 64'h0, 64'h7);

    phase_base[0] = '0;
    phase_limit[0] = '0;
    phase_items[0] = 40;
    phase_base[1] = '0;
    phase_limit[1] = '1;
    phase_items[1] = 180;
    phase_base[2] = rand64() & 64'hFFFF_FFFF_FFF0_0000;
    phase_limit[2] = phase_base[2] + 64'hFFFF;
    phase_items[2] = 180;
    phase_base[3] = '1;
    phase_limit[3] = '1;
    phase_items[3] = 40;
    phase_base[4] = 64'hFFFF_FFFF_FFFF_FC00;
    phase_limit[4] = '1;
    phase_items[4] = 110;
    phase_base[5] = 64'h8000;
    phase_limit[5] = 64'h7FFF;
    phase_items[5] = 30;
    phase_base[6] = rand64() & 64'hFFFF_FFFF_FFF0_0000;
    phase_limit[6] = phase_base[6] + 64'hFFFF;
    phase_items[6] = 170;

    for (int p = 0; p < 7; p++) begin
      configure(phase_base[p], phase_limit[p]);
      sent_in_phase = 0;
      steady = (p == 1);
      if (p == 1 || p == 2) load_run($urandom_range(52, 70));
      while (sent_in_phase < phase_items[p]) begin
        if (p == 1 && sent_in_phase >= 60) steady = 1'b0;
        if (p == 2 && sent_in_phase >= 90 && sent_in_phase < 97) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send_noise();
        end else if (pick < 13) begin
          load_run($urandom_range(50, 65));
        end else begin
          run_len = $urandom_range(1, 6);
          load_run(run_len);
          send_jump();
        end
      end
    end

    steady = 1'b0;
    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("load_to_indirect_jump_correlator regression: pass");
    end else begin
      $display("load_to_indirect_jump_correlator regression: fail");
    end
    $finish;
  end
endmodule
